FILE: rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and codes for the byte-addressed stack
// Item layouts of both channels, status and operation codes, and the request
// that the control logic sends to each byte bank.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    // One byte lane per byte of the widest item.
    localparam int NUM_BANKS  = 8;
    localparam int MAX_BYTES  = 8;

    // Input item.
    typedef struct packed {
        logic        op;
        logic [3:0]  byte_count;
        logic [63:0] push_value;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [63:0] pop_value;
        logic [1:0]  status;
        logic [8:0]  fill_count;
    } t_out_item;

    // Access request to one bank.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_bank_req;

endpackage

FILE: rtl/bsm_bank.sv
// ----------------------------------------------------------------------------
// bsm_bank: one byte lane of the stack store
// Single-port synchronous memory, one byte wide, with a registered read.
// ----------------------------------------------------------------------------
module bsm_bank #(
    parameter int ROWS = 32,
    parameter int RW   = 5
) (
    input  logic               i_clk,
    input  bsm_pkg::t_bank_req i_req,
    input  logic [RW-1:0]      i_row,
    input  logic [7:0]         i_wdata,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_rdata;

    // Write and registered read share the one port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_row] <= i_wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/byte_stack_multiwidth.sv
// ----------------------------------------------------------------------------
// byte_stack_multiwidth: byte-addressed last-in-first-out store
// Pushes or pops up to eight bytes per item, little-endian, in eight byte
// banks; refuses overflow and underflow and reports the fill count.
// ----------------------------------------------------------------------------
// A push loads the result register when it is accepted; a pop first passes the
// registered read of the byte banks. Throughput: one push per cycle while the
// result register is free or being emptied; after a pop the input is not ready until its result is loaded.
// Reset (synchronous): the fill count and the handshake state clear; the byte
// store is not cleared, since only bytes below the fill count are ever read.
// ----------------------------------------------------------------------------
module byte_stack_multiwidth #(
    parameter int DEPTH_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bsm_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bsm_pkg::t_out_item  o_out_item
);

    localparam int HW   = $clog2(DEPTH_BYTES + 1);
    localparam int ROWS = (DEPTH_BYTES + bsm_pkg::NUM_BANKS - 1) / bsm_pkg::NUM_BANKS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef logic [HW-1:0] t_held;

    localparam t_held DEPTH_H = t_held'(DEPTH_BYTES);

    // State codes.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                r_state, n_state;
    t_held               r_held, n_held;
    logic                r_out_valid, n_out_valid;
    bsm_pkg::t_out_item  r_out, n_out;
    logic [2:0]          r_base_lo, n_base_lo;
    logic [3:0]          r_count, n_count;

    logic                accept;
    logic [3:0]          count_sat;
    t_held               count_h;
    t_held               base;
    logic                push_ok;
    logic                pop_ok;

    bsm_pkg::t_bank_req  bank_req   [bsm_pkg::NUM_BANKS];
    logic [RW-1:0]       bank_row   [bsm_pkg::NUM_BANKS];
    logic [7:0]          bank_wdata [bsm_pkg::NUM_BANKS];
    logic [7:0]          bank_rdata [bsm_pkg::NUM_BANKS];
    logic [63:0]         pop_data;

    // Ready while idle and the result register is free or being emptied.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Byte count above eight behaves as eight.
    assign count_sat = (i_in_item.byte_count > 4'(bsm_pkg::MAX_BYTES)) ?
                       4'(bsm_pkg::MAX_BYTES) : i_in_item.byte_count;
    assign count_h   = t_held'(count_sat);

    // Room and occupancy checks.
    assign push_ok = count_h <= (DEPTH_H - r_held);
    assign pop_ok  = r_held >= count_h;

    // Lowest address that the item touches.
    assign base = (i_in_item.op == bsm_pkg::OP_PUSH) ? r_held : (r_held - count_h);

    // Bank addressing: bank b holds the byte of the item at offset k.
    always_comb begin
        for (int b = 0; b < bsm_pkg::NUM_BANKS; b++) begin
            logic [2:0] k;
            logic       active;
            t_held      addr;
            k      = 3'(b) - base[2:0];
            active = {1'b0, k} < count_sat;
            addr   = base + t_held'(k);
            bank_row[b]     = RW'(addr >> 3);
            bank_wdata[b]   = i_in_item.push_value[8*k +: 8];
            bank_req[b].wr_en = accept && active &&
                                (i_in_item.op == bsm_pkg::OP_PUSH) && push_ok;
            bank_req[b].rd_en = accept && active &&
                                (i_in_item.op == bsm_pkg::OP_POP) && pop_ok;
        end
    end

    // Byte banks.
    for (genvar g = 0; g < bsm_pkg::NUM_BANKS; g++) begin : g_bank
        bsm_bank #(
            .ROWS (ROWS),
            .RW   (RW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_req   (bank_req[g]),
            .i_row   (bank_row[g]),
            .i_wdata (bank_wdata[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    // Reassemble popped bytes little-endian, zero above the byte count.
    always_comb begin
        pop_data = '0;
        for (int i = 0; i < bsm_pkg::MAX_BYTES; i++) begin
            logic [2:0] sel;
            sel = r_base_lo + 3'(i);
            if (4'(i) < r_count) begin
                pop_data[8*i +: 8] = bank_rdata[sel];
            end
        end
    end

    // Control: decide the item, update the fill count, load the result.
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_out       = r_out;
        n_base_lo   = r_base_lo;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_item.op == bsm_pkg::OP_PUSH) begin
                        n_out.pop_value = '0;
                        if (push_ok) begin
                            n_held       = r_held + count_h;
                            n_out.status = bsm_pkg::ST_OK;
                        end else begin
                            n_out.status = bsm_pkg::ST_OVER;
                        end
                        n_out.fill_count = 9'(n_held);
                        n_out_valid      = 1'b1;
                    end else if (pop_ok) begin
                        n_held    = base;
                        n_base_lo = base[2:0];
                        n_count   = count_sat;
                        n_state   = S_READ;
                    end else begin
                        n_out.pop_value  = '0;
                        n_out.status     = bsm_pkg::ST_UNDER;
                        n_out.fill_count = 9'(r_held);
                        n_out_valid      = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_out.pop_value  = pop_data;
                n_out.status     = bsm_pkg::ST_OK;
                n_out.fill_count = 9'(r_held);
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_base_lo <= n_base_lo;
        r_count   <= n_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
